[rtl/core/dqd_pkg.sv]
// ----------------------------------------------------------------------------
// dqd_pkg
// shared sizes, codes and word helpers for the double-ended queue
// ----------------------------------------------------------------------------
package dqd_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // wide enough to hold DEPTH itself
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef logic [DATA_WIDTH-1:0] t_word;
    typedef logic [CNT_W-1:0]      t_cnt;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_POP_BACK   = 3'd1,
        OP_UNSHIFT    = 3'd2,
        OP_SHIFT      = 3'd3,
        OP_DELETE     = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOMATCH = 2'd3
    } t_status;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic  push_back;
        logic  unshift;
        logic  shift_front;
        logic  del;
        t_word value;
        t_cnt  count;
    } t_cell_cmd;

    function automatic t_word in_to_word(input logic signed [VALUE_W-1:0] v);
        return t_word'(v);
    endfunction

    function automatic logic [VALUE_W-1:0] word_to_out(input t_word w);
        return VALUE_W'(signed'(w));
    endfunction

endpackage

[rtl/core/dqd_req_if.sv]
// ----------------------------------------------------------------------------
// dqd_req_if
// request channel: operation code and operand word
// ----------------------------------------------------------------------------
interface dqd_req_if;
    import dqd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

[rtl/core/dqd_rsp_if.sv]
// ----------------------------------------------------------------------------
// dqd_rsp_if
// response channel: removed word, status and entry count
// ----------------------------------------------------------------------------
interface dqd_rsp_if;
    import dqd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] data;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_W-1:0]        count;

    modport source (output valid, output data, output status, output count, input ready);
    modport sink   (input valid, input data, input status, input count, output ready);
endinterface

[rtl/core/dqd_cell.sv]
// ----------------------------------------------------------------------------
// dqd_cell
// one storage slot of the queue; takes its next word from the request,
// its left neighbor or its right neighbor
// ----------------------------------------------------------------------------
module dqd_cell
    import dqd_pkg::*;
(
    input  logic      i_clk,
    input  t_cnt      i_pos,
    input  t_cell_cmd i_cmd,
    input  t_word     i_left_word,
    input  t_word     i_right_word,
    input  logic      i_hit,
    input  t_word     i_tail,
    output t_word     o_word,
    output logic      o_hit,
    output t_word     o_tail
);

    t_word r_word;
    t_word n_word;
    logic  occupied;

    assign occupied = (i_pos < i_cmd.count);
    // first match seen at or in front of this slot
    assign o_hit    = i_hit || (occupied && (r_word == i_cmd.value));
    // pick up the back entry as it passes along the row
    assign o_tail   = i_tail | (((i_pos + t_cnt'(1)) == i_cmd.count) ? r_word : '0);
    assign o_word   = r_word;

    always_comb begin
        n_word = r_word;
        if (i_cmd.unshift) begin
            n_word = (i_pos == '0) ? i_cmd.value : i_left_word;
        end else if (i_cmd.push_back && (i_pos == i_cmd.count)) begin
            n_word = i_cmd.value;
        end else if (i_cmd.shift_front || (i_cmd.del && o_hit)) begin
            n_word = i_right_word;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

endmodule

[rtl/core/deque_with_delete_by_value.sv]
// ----------------------------------------------------------------------------
// deque_with_delete_by_value
// bounded double-ended queue of words with delete of the first match
// ----------------------------------------------------------------------------
// The queue is a row of DEPTH slots, front at slot 0. Every operation (push
// back, pop back, unshift, shift, delete first match) acts on the whole row:
// all slots compare against the operand and move toward their neighbor
// together, so a new request is taken every cycle while the response register
// can hand its beat on. Cycle time is set by the match and back-entry chains
// that ripple across the row of slots. Each request gives exactly one response
// beat: the removed word (all ones for a delete or when nothing was removed),
// a status (ok, empty, full, no match) and the count held afterwards. Inserts
// into a full queue are dropped and flagged full.
module deque_with_delete_by_value
    import dqd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    dqd_req_if.sink   i_req,
    dqd_rsp_if.source o_rsp
);

    t_cnt        r_cnt;
    t_cnt        n_cnt;
    logic        r_out_valid;
    logic [VALUE_W-1:0] r_data;
    logic [VALUE_W-1:0] n_data;
    t_status     r_status;
    t_status     n_status;
    logic [COUNT_W-1:0] r_out_count;

    logic        accept;
    logic        full;
    logic        empty;
    logic        found;
    t_word       req_word;
    t_cell_cmd   cmd;

    t_word       words [DEPTH];
    logic        hits  [DEPTH+1];
    t_word       tails [DEPTH+1];

    assign i_req.ready = !r_out_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign full        = (r_cnt == t_cnt'(DEPTH));
    assign empty       = (r_cnt == '0);
    assign req_word    = in_to_word(i_req.value);
    assign found       = hits[DEPTH];

    assign hits[0]  = 1'b0;
    assign tails[0] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        dqd_cell u_cell (
            .i_clk        (i_clk),
            .i_pos        (t_cnt'(g)),
            .i_cmd        (cmd),
            .i_left_word  ((g == 0) ? req_word : words[(g == 0) ? 0 : g-1]),
            .i_right_word (words[(g == DEPTH-1) ? g : g+1]),
            .i_hit        (hits[g]),
            .i_tail       (tails[g]),
            .o_word       (words[g]),
            .o_hit        (hits[g+1]),
            .o_tail       (tails[g+1])
        );
    end

    always_comb begin
        cmd             = '0;
        cmd.value       = req_word;
        cmd.count       = r_cnt;
        n_cnt           = r_cnt;
        n_data          = '1;
        n_status        = ST_OK;
        case (t_op'(i_req.op))
            OP_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    cmd.push_back = accept;
                    n_cnt         = r_cnt + t_cnt'(1);
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_data = word_to_out(tails[DEPTH]);
                    n_cnt  = r_cnt - t_cnt'(1);
                end
            end
            OP_UNSHIFT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    cmd.unshift = accept;
                    n_cnt       = r_cnt + t_cnt'(1);
                end
            end
            OP_SHIFT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    cmd.shift_front = accept;
                    n_data          = word_to_out(words[0]);
                    n_cnt           = r_cnt - t_cnt'(1);
                end
            end
            OP_DELETE: begin
                if (found) begin
                    cmd.del = accept;
                    n_cnt   = r_cnt - t_cnt'(1);
                end else begin
                    n_status = ST_NOMATCH;
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_cnt       <= n_cnt;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // response payload, loaded on each accepted beat
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data      <= n_data;
            r_status    <= n_status;
            r_out_count <= COUNT_W'(n_cnt);
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.data   = r_data;
    assign o_rsp.status = r_status;
    assign o_rsp.count  = r_out_count;

endmodule

[verif/deque_with_delete_by_value_tb.sv]
// ----------------------------------------------------------------------------
// deque_with_delete_by_value_tb
// self-checking bench for the double-ended queue with delete by value
// ----------------------------------------------------------------------------
// A short table of directed requests covers the empty and full corners, the
// unused operation codes and the word extremes. Random traffic follows, biased
// in alternating phases toward filling and draining so the queue sweeps its
// whole range, with deletes aimed mostly at words that were recently inserted.
// Every response beat is compared field by field against the row's own result
// for typed directed rows, else against a behavioral queue kept in the bench.
// Requests come in bursts with gaps, responses stall on a pattern of their own.
module deque_with_delete_by_value_tb;
    import dqd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [VALUE_W-1:0] NO_DATA     = '1;
    localparam logic [OP_W-1:0]    OP_UNUSED_5 = 3'd5;
    localparam logic [OP_W-1:0]    OP_UNUSED_6 = 3'd6;
    localparam logic [OP_W-1:0]    OP_UNUSED_7 = 3'd7;
    localparam int                 RANDOM_ITEMS = 1600;
    localparam int                 RECENT_MAX   = 24;

    typedef struct packed {
        logic [VALUE_W-1:0] data;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } deque_result_t;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        logic [4:0]         reps;
        bit                 typed;
        deque_result_t      result;
    } directed_row_t;

    localparam int N_ROWS = 20;

    // typed rows carry their result, the others go through the queue model
    directed_row_t directed_rows [N_ROWS] = '{
        '{OP_POP_BACK,  32'h0000_0000, 5'd1,  1'b1, '{NO_DATA, ST_EMPTY,   5'd0}},
        '{OP_SHIFT,     32'hffff_ffff, 5'd1,  1'b1, '{NO_DATA, ST_EMPTY,   5'd0}},
        '{OP_DELETE,    32'h0000_0000, 5'd1,  1'b1, '{NO_DATA, ST_NOMATCH, 5'd0}},
        '{OP_UNUSED_5,  32'hffff_ffff, 5'd1,  1'b1, '{NO_DATA, ST_OK,      5'd0}},
        '{OP_UNUSED_6,  32'h0000_0000, 5'd1,  1'b1, '{NO_DATA, ST_OK,      5'd0}},
        '{OP_UNUSED_7,  32'h1234_5678, 5'd1,  1'b1, '{NO_DATA, ST_OK,      5'd0}},
        '{OP_PUSH_BACK, 32'h7fff_ffff, 5'd1,  1'b1, '{NO_DATA, ST_OK,      5'd1}},
        '{OP_UNSHIFT,   32'h8000_0000, 5'd1,  1'b1, '{NO_DATA, ST_OK,      5'd2}},
        '{OP_PUSH_BACK, 32'h0000_0000, 5'd1,  1'b1, '{NO_DATA, ST_OK,      5'd3}},
        '{OP_PUSH_BACK, 32'hffff_ffff, 5'd1,  1'b1, '{NO_DATA, ST_OK,      5'd4}},
        '{OP_DELETE,    32'h1234_5678, 5'd1,  1'b1, '{NO_DATA, ST_NOMATCH, 5'd4}},
        '{OP_DELETE,    32'hffff_ffff, 5'd1,  1'b1, '{NO_DATA, ST_OK,      5'd3}},
        '{OP_SHIFT,     32'h0000_0000, 5'd1,  1'b1, '{32'h8000_0000, ST_OK, 5'd2}},
        '{OP_POP_BACK,  32'h0000_0000, 5'd1,  1'b1, '{32'h0000_0000, ST_OK, 5'd1}},
        // fill up to the top with duplicates
        '{OP_UNSHIFT,   32'h5a5a_5a5a, 5'd15, 1'b0, '{NO_DATA, ST_OK,      5'd0}},
        '{OP_PUSH_BACK, 32'ha5a5_a5a5, 5'd1,  1'b1, '{NO_DATA, ST_FULL,    5'd16}},
        '{OP_UNSHIFT,   32'h0000_0001, 5'd1,  1'b1, '{NO_DATA, ST_FULL,    5'd16}},
        '{OP_DELETE,    32'h5a5a_5a5a, 5'd1,  1'b1, '{NO_DATA, ST_OK,      5'd15}},
        '{OP_POP_BACK,  32'h0000_0000, 5'd1,  1'b1, '{32'h7fff_ffff, ST_OK, 5'd14}},
        '{OP_DELETE,    32'h7fff_ffff, 5'd1,  1'b1, '{NO_DATA, ST_NOMATCH, 5'd14}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    dqd_req_if req_ch ();
    dqd_rsp_if rsp_ch ();

    deque_with_delete_by_value i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("deque_with_delete_by_value regression: fail");
        $finish;
    end

    // queue model and bookkeeping
    t_word              deque_words [$];
    deque_result_t      pending_results [$];
    logic [VALUE_W-1:0] recent_inserts [$];
    int unsigned        err_count = 0;
    int unsigned        beat_count = 0;

    // typed expectation travels with the request beat
    logic          req_typed = 1'b0;
    deque_result_t req_typed_result = '0;

    int unsigned burst_left = 0;

    task automatic report_error(input string msg);
        $display("error at beat %0d: %s", beat_count, msg);
        err_count++;
    endtask

    function automatic logic [VALUE_W-1:0] widen_word(input t_word w);
        logic signed [DATA_WIDTH-1:0] sw;
        sw = w;
        return VALUE_W'(sw);
    endfunction

    function automatic deque_result_t apply_deque_op(input logic [OP_W-1:0] op,
                                                     input logic [VALUE_W-1:0] value);
        deque_result_t res;
        t_word         w;
        w          = t_word'($signed(value));
        res.data   = NO_DATA;
        res.status = ST_OK;
        case (op)
            OP_PUSH_BACK: begin
                if (deque_words.size() >= DEPTH) res.status = ST_FULL;
                else deque_words.push_back(w);
            end
            OP_POP_BACK: begin
                if (deque_words.size() == 0) res.status = ST_EMPTY;
                else res.data = widen_word(deque_words.pop_back());
            end
            OP_UNSHIFT: begin
                if (deque_words.size() >= DEPTH) res.status = ST_FULL;
                else deque_words.push_front(w);
            end
            OP_SHIFT: begin
                if (deque_words.size() == 0) res.status = ST_EMPTY;
                else res.data = widen_word(deque_words.pop_front());
            end
            OP_DELETE: begin
                res.status = ST_NOMATCH;
                for (int i = 0; i < deque_words.size(); i++) begin
                    if (deque_words[i] == w) begin
                        deque_words.delete(i);
                        res.status = ST_OK;
                        break;
                    end
                end
            end
            default: ;
        endcase
        res.count = COUNT_W'(deque_words.size());
        return res;
    endfunction

    // scoreboard: check the response beat first, it belongs to an older request
    always @(posedge i_clk) begin
        deque_result_t want;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                beat_count++;
                if (pending_results.size() == 0) begin
                    report_error($sformatf("response beat with nothing pending (data %h)",
                                           rsp_ch.data));
                end else begin
                    want = pending_results.pop_front();
                    if (rsp_ch.data !== want.data)
                        report_error($sformatf("data %h, want %h", rsp_ch.data, want.data));
                    if (rsp_ch.status !== want.status)
                        report_error($sformatf("status %0d, want %0d",
                                               rsp_ch.status, want.status));
                    if (rsp_ch.count !== want.count)
                        report_error($sformatf("count %0d, want %0d",
                                               rsp_ch.count, want.count));
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                want = apply_deque_op(req_ch.op, req_ch.value);
                if (req_typed) want = req_typed_result;
                pending_results.push_back(want);
            end
        end
    end

    // receiver stalls: one of four ready patterns, chosen anew at random
    int unsigned stall_mode  = 0;
    int unsigned stall_left  = 0;
    int unsigned stall_phase = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(20, 200);
            end
            stall_left--;
            stall_phase++;
            case (stall_mode)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
                2: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                default: rsp_ch.ready <= (stall_phase % 5 < 3);
            endcase
        end
    end

    // one request beat; holds valid across a burst, drops it for the gap
    task automatic drive_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
                                 input bit typed, input deque_result_t result);
        if (burst_left == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        req_ch.valid     <= 1'b1;
        req_ch.op        <= op;
        req_ch.value     <= value;
        req_typed        <= typed;
        req_typed_result <= result;
        do @(posedge i_clk); while (!req_ch.ready);
        if (op == OP_PUSH_BACK || op == OP_UNSHIFT) begin
            recent_inserts.push_back(value);
            if (recent_inserts.size() > RECENT_MAX) void'(recent_inserts.pop_front());
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_word();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 32'hffff_ffff;
                    default: return 32'h0000_0000;
                endcase
            end
            // small words give duplicates, so delete must pick the first one
            default: return $urandom_range(0, 7);
        endcase
    endfunction

    initial begin : stimulus
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] value;
        int unsigned        roll;
        int unsigned        phase_left;
        bit                 filling;

        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op    = '0;
        req_ch.value = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_ROWS; r++) begin
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                drive_request(directed_rows[r].op, directed_rows[r].value,
                              directed_rows[r].typed, directed_rows[r].result);
            end
        end

        filling    = 1'b0;
        phase_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (phase_left == 0) begin
                filling    = !filling;
                phase_left = $urandom_range(40, 120);
            end
            phase_left--;
            roll = $urandom_range(0, 99);
            if (filling) begin
                if (roll < 35)      op = OP_PUSH_BACK;
                else if (roll < 65) op = OP_UNSHIFT;
                else if (roll < 75) op = OP_POP_BACK;
                else if (roll < 85) op = OP_SHIFT;
                else if (roll < 97) op = OP_DELETE;
                else                op = OP_W'($urandom_range(OP_UNUSED_5, OP_UNUSED_7));
            end else begin
                if (roll < 12)      op = OP_PUSH_BACK;
                else if (roll < 24) op = OP_UNSHIFT;
                else if (roll < 50) op = OP_POP_BACK;
                else if (roll < 76) op = OP_SHIFT;
                else if (roll < 97) op = OP_DELETE;
                else                op = OP_W'($urandom_range(OP_UNUSED_5, OP_UNUSED_7));
            end
            if (op == OP_DELETE && recent_inserts.size() != 0 && $urandom_range(0, 9) < 7)
                value = recent_inserts[$urandom_range(0, recent_inserts.size() - 1)];
            else
                value = pick_word();
            drive_request(op, value, 1'b0, '0);
        end
        req_ch.valid <= 1'b0;

        // let the scoreboard log the last request beat before draining
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("deque_with_delete_by_value regression: pass");
        else
            $display("deque_with_delete_by_value regression: fail");
        $finish;
    end

endmodule
